// ===== hdl/wsp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package wsp_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int COEF_W = 32;
    localparam int POS_W = 32;
    localparam int PROD_W = COEF_W + POS_W;
    localparam int MAT_N = 16;
    localparam int IDX_W = 4;
    localparam int NDC_CAP_LOG2 = 40;
    localparam int QUO_W = NDC_CAP_LOG2 + 1;
    localparam int NDC_W = QUO_W + 1;
    localparam int SCR_W = 13;
    localparam int NEAR_W = 17;
    localparam int SCREEN_W = 32;

    localparam int S_TDATA_W = 136;
    localparam int M_TDATA_W = 64;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = NEAR_W;

    localparam logic [SCR_W-1:0] WIDTH_RST = SCR_W'(1920);
    localparam logic [SCR_W-1:0] HEIGHT_RST = SCR_W'(1080);
    localparam logic [NEAR_W-1:0] NEAR_RST = NEAR_W'(6554);

    typedef enum logic {
        KIND_LOAD = 1'b0,
        KIND_PROJECT = 1'b1
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_NEAR = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic wr_en;
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    // A load item carries its coefficient in the x slot.
    typedef struct packed {
        t_kind kind;
        logic [IDX_W-1:0] idx;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
    } t_entry;

endpackage

`default_nettype wire

// ===== hdl/world_to_screen_projection.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Projects world points to viewport pixels through a 4x4 view matrix.
// Input beats (s side): tuser is the kind, 0 loads one matrix coefficient
// and 1 projects a point. Load beats give no output beat; project beats
// give exactly one, in order. Output beats (m side) carry screen x and y in
// signed fixed point, with tuser set when the point lies behind the camera,
// in which case both positions are zero.
// Throughput is one beat per cycle while the m side takes beats. A project
// beat with no stall passes from the input handshake to the output through
// an input register, the queue, the snapshot, product, sum and sign stages
// of the matrix product, 41 stages of the restoring dividers (one quotient
// bit each) and the rounding, viewport scaling and saturation registers.
// A stall on the m side freezes the back pipeline; the four-entry queue and
// the input register keep taking input beats until full, then tready falls.
// Reset clears the matrix to zero and loads width 1920, height 1080 and a
// near limit of 0.1. Configuration writes are taken at once, one register
// per cycle, and should only happen while no beat is in flight.
module world_to_screen_projection #(
    parameter int FRAC_BITS = wsp_pkg::FRAC_BITS_DEF,
    parameter int QUEUE_DEPTH = wsp_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_wr_en,
    input  wire logic [wsp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [wsp_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    // coef_index[3:0], coef_value[35:4], pos_x[67:36], pos_y[99:68],
    // pos_z[131:100], zero pad
    input  wire logic [wsp_pkg::S_TDATA_W-1:0]   i_s_tdata,
    // kind[0]
    input  wire logic                            i_s_tuser,
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    // screen_x[31:0], screen_y[63:32]
    output logic [wsp_pkg::M_TDATA_W-1:0]        o_m_tdata,
    // behind_camera[0]
    output logic                                 o_m_tuser
);
    import wsp_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH+1);

    t_cfg_wr          w_cfg;
    t_entry           w_front_entry;
    t_entry           w_q_entry;
    logic             w_push;
    logic             w_pop;
    logic             w_q_full;
    logic             w_q_empty;
    logic [CNT_W-1:0] w_q_count;

    always_comb begin
        w_cfg.wr_en = i_cfg_wr_en;
        w_cfg.index = i_cfg_index;
        w_cfg.data = i_cfg_data;
    end

    wsp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_push     (w_push),
        .o_entry    (w_front_entry),
        .i_q_full   (w_q_full)
    );

    wsp_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_front_entry),
        .i_pop   (w_pop),
        .o_entry (w_q_entry),
        .o_full  (w_q_full),
        .o_empty (w_q_empty),
        .o_count (w_q_count)
    );

    wsp_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_entry    (w_q_entry),
        .i_q_empty  (w_q_empty),
        .o_pop      (w_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

`ifndef SYNTH
    a_behind_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tdata == '0))
        else $error("behind-camera beat carries a non-zero position");

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_count <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count exceeds its depth");

    a_no_pop_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !(o_m_tvalid && !i_m_tready))
        else $error("queue popped while the output is stalled");

    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (w_q_count == $past(w_q_count) + CNT_W'(1)))
        else $error("queue count lost a push");
`endif

endmodule

`default_nettype wire

// ===== hdl/wsp_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wsp_front (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    input  wire logic [wsp_pkg::S_TDATA_W-1:0]   i_s_tdata,
    input  wire logic                            i_s_tuser,
    output logic                                 o_push,
    output wsp_pkg::t_entry                      o_entry,
    input  wire logic                            i_q_full
);
    import wsp_pkg::*;

    logic   r_valid;
    t_entry r_entry;
    t_entry n_entry;
    logic   w_take;

    assign o_push = r_valid && !i_q_full;
    assign o_s_tready = !r_valid || !i_q_full;
    assign w_take = i_s_tvalid && o_s_tready;

    always_comb begin
        n_entry.kind = t_kind'(i_s_tuser);
        n_entry.idx = i_s_tdata[3:0];
        n_entry.y = i_s_tdata[99:68];
        n_entry.z = i_s_tdata[131:100];
        // Load beats put the coefficient where the x coordinate would travel.
        if (n_entry.kind == KIND_LOAD) begin
            n_entry.x = i_s_tdata[35:4];
        end else begin
            n_entry.x = i_s_tdata[67:36];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
        if (w_take) begin
            r_entry <= n_entry;
        end
    end

    assign o_entry = r_entry;

endmodule

`default_nettype wire

// ===== hdl/wsp_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wsp_fifo #(
    parameter int DEPTH = wsp_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_push,
    input  wire wsp_pkg::t_entry             i_entry,
    input  wire logic                        i_pop,
    output wsp_pkg::t_entry                  o_entry,
    output logic                             o_full,
    output logic                             o_empty,
    output logic [$clog2(DEPTH+1)-1:0]       o_count
);
    import wsp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH+1);

    t_entry             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(DEPTH-1)) begin
            return '0;
        end
        return p + PTR_W'(1);
    endfunction

    assign o_full = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_entry = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/wsp_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per stage. The top NUM_W-QUO_W bits of
// the numerator must be below the divisor for the quotient to be exact.
module wsp_div #(
    parameter int NUM_W = 66,
    parameter int DEN_W = 50,
    parameter int QUO_W = 41
) (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic [NUM_W-1:0]   i_num,
    input  wire logic [DEN_W-1:0]   i_den,
    output logic [QUO_W-1:0]        o_quo,
    output logic                    o_rem_nz
);

    logic [DEN_W-1:0] r_rem [QUO_W];
    logic [NUM_W-1:0] r_num [QUO_W];
    logic [DEN_W-1:0] r_den [QUO_W];
    logic [QUO_W-1:0] r_quo [QUO_W];

    for (genvar k = 0; k < QUO_W; k++) begin : g_step
        logic [DEN_W-1:0] w_rin;
        logic [DEN_W-1:0] w_din;
        logic [NUM_W-1:0] w_nin;
        logic [QUO_W-1:0] w_qin;
        logic [DEN_W-1:0] w_t;

        if (k == 0) begin : g_first
            assign w_rin = DEN_W'(i_num[NUM_W-1:QUO_W]);
            assign w_din = i_den;
            assign w_nin = i_num;
            assign w_qin = '0;
        end else begin : g_next
            assign w_rin = r_rem[k-1];
            assign w_din = r_den[k-1];
            assign w_nin = r_num[k-1];
            assign w_qin = r_quo[k-1];
        end

        assign w_t = {w_rin[DEN_W-2:0], w_nin[QUO_W-1-k]};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[k] <= w_nin;
                r_den[k] <= w_din;
                if (w_t >= w_din) begin
                    r_rem[k] <= w_t - w_din;
                    r_quo[k] <= {w_qin[QUO_W-2:0], 1'b1};
                end else begin
                    r_rem[k] <= w_t;
                    r_quo[k] <= {w_qin[QUO_W-2:0], 1'b0};
                end
            end
        end
    end

    assign o_quo = r_quo[QUO_W-1];
    assign o_rem_nz = (r_rem[QUO_W-1] != '0);

endmodule

`default_nettype wire

// ===== hdl/wsp_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wsp_back #(
    parameter int FRAC_BITS = wsp_pkg::FRAC_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire wsp_pkg::t_cfg_wr                i_cfg,
    input  wire wsp_pkg::t_entry                 i_entry,
    input  wire logic                            i_q_empty,
    output logic                                 o_pop,
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    output logic [wsp_pkg::M_TDATA_W-1:0]        o_m_tdata,
    output logic                                 o_m_tuser
);
    import wsp_pkg::*;

    localparam int CLIP_W = PROD_W - FRAC_BITS + 2;
    localparam int NUM_W = CLIP_W + FRAC_BITS;
    localparam int TERM_W = NDC_W + 1;
    localparam int MUL_W = TERM_W + SCR_W + 1;
    localparam int DLY = QUO_W;

    typedef struct packed {
        logic valid;
        logic behind;
        logic neg_x;
        logic neg_y;
        logic ov_x;
        logic ov_y;
    } t_side;

    // Configuration registers.
    logic [SCR_W-1:0]  r_width;
    logic [SCR_W-1:0]  r_height;
    logic [NEAR_W-1:0] r_near;

    logic signed [COEF_W-1:0] r_mat [MAT_N];

    logic w_en;
    assign w_en = !(o_m_tvalid && !i_m_tready);
    assign o_pop = w_en && !i_q_empty;

    // Stage 1: point and a snapshot of rows 0, 1 and 3.
    logic                      r_s1_valid;
    logic signed [POS_W-1:0]   r_s1_x, r_s1_y, r_s1_z;
    logic signed [COEF_W-1:0]  r_s1_m [12];

    // Stage 2: products.
    logic                      r_s2_valid;
    logic signed [PROD_W-1:0]  r_s2_p [9];
    logic signed [COEF_W-1:0]  r_s2_c [3];

    // Stage 3: clip coordinates.
    logic                      r_s3_valid;
    logic signed [CLIP_W-1:0]  r_s3_clip [3];

    // Stage 4: sign and magnitude, behind-camera test.
    logic                      r_s4_valid;
    logic                      r_s4_behind;
    logic                      r_s4_neg_x, r_s4_neg_y;
    logic [CLIP_W-1:0]         r_s4_mag_x, r_s4_mag_y;
    logic [CLIP_W-1:0]         r_s4_den;

    t_side                     r_side [DLY];

    // Stage 6: normalised device coordinates.
    logic                      r_s6_valid;
    logic                      r_s6_behind;
    logic signed [NDC_W-1:0]   r_s6_ndc_x, r_s6_ndc_y;

    // Stage 7: viewport products.
    logic                      r_s7_valid;
    logic                      r_s7_behind;
    logic signed [MUL_W-1:0]   r_s7_px, r_s7_py;

    logic [M_TDATA_W-1:0]      r_out_data;
    logic                      r_out_behind;
    logic                      r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= WIDTH_RST;
            r_height <= HEIGHT_RST;
            r_near <= NEAR_RST;
        end else if (i_cfg.wr_en) begin
            unique case (t_reg_idx'(i_cfg.index))
                REG_WIDTH:  r_width <= i_cfg.data[SCR_W-1:0];
                REG_HEIGHT: r_height <= i_cfg.data[SCR_W-1:0];
                REG_NEAR:   r_near <= i_cfg.data;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAT_N; i++) begin
                r_mat[i] <= '0;
            end
        end else if (o_pop && i_entry.kind == KIND_LOAD) begin
            r_mat[i_entry.idx] <= i_entry.x;
        end
    end

    // Floored fixed-point product widened to the clip width.
    function automatic logic signed [CLIP_W-1:0] fl(input logic signed [PROD_W-1:0] p);
        return {{2{p[PROD_W-1]}}, p[PROD_W-1:FRAC_BITS]};
    endfunction

    function automatic logic signed [CLIP_W-1:0] cx(input logic signed [COEF_W-1:0] c);
        return {{(CLIP_W-COEF_W){c[COEF_W-1]}}, c};
    endfunction

    function automatic logic [CLIP_W-1:0] mag(input logic signed [CLIP_W-1:0] v);
        return v[CLIP_W-1] ? CLIP_W'(-v) : CLIP_W'(v);
    endfunction

    function automatic logic signed [NDC_W-1:0] ndc(input logic [QUO_W-1:0] q,
                                                    input logic rem_nz,
                                                    input logic neg,
                                                    input logic ov);
        logic [NDC_W-1:0] m;
        m = {1'b0, q} + NDC_W'(neg && rem_nz);
        if (ov || m > (NDC_W'(1) << NDC_CAP_LOG2)) begin
            m = NDC_W'(1) << NDC_CAP_LOG2;
        end
        return neg ? NDC_W'(-m) : NDC_W'(m);
    endfunction

    function automatic logic [SCREEN_W-1:0] sat(input logic signed [MUL_W-1:0] p);
        logic signed [MUL_W-1:0] s;
        s = p >>> 1;
        if (&s[MUL_W-1:SCREEN_W-1] || ~|s[MUL_W-1:SCREEN_W-1]) begin
            return s[SCREEN_W-1:0];
        end
        return s[MUL_W-1] ? {1'b1, {(SCREEN_W-1){1'b0}}} : {1'b0, {(SCREEN_W-1){1'b1}}};
    endfunction

    logic [NUM_W-1:0] w_num_x, w_num_y;
    logic             w_ov_x, w_ov_y;
    logic [QUO_W-1:0] w_quo_x, w_quo_y;
    logic             w_rnz_x, w_rnz_y;
    t_side            w_side_in;
    t_side            w_side_out;
    logic signed [TERM_W-1:0] w_one;

    assign w_num_x = {r_s4_mag_x, {FRAC_BITS{1'b0}}};
    assign w_num_y = {r_s4_mag_y, {FRAC_BITS{1'b0}}};
    // Quotient would need more bits than the cap allows: clamp it.
    assign w_ov_x = CLIP_W'(w_num_x[NUM_W-1:QUO_W]) >= r_s4_den;
    assign w_ov_y = CLIP_W'(w_num_y[NUM_W-1:QUO_W]) >= r_s4_den;
    assign w_one = TERM_W'(1) << FRAC_BITS;

    always_comb begin
        w_side_in.valid = r_s4_valid;
        w_side_in.behind = r_s4_behind;
        w_side_in.neg_x = r_s4_neg_x;
        w_side_in.neg_y = r_s4_neg_y;
        w_side_in.ov_x = w_ov_x;
        w_side_in.ov_y = w_ov_y;
    end
    assign w_side_out = r_side[DLY-1];

    wsp_div #(
        .NUM_W (NUM_W),
        .DEN_W (CLIP_W),
        .QUO_W (QUO_W)
    ) u_div_x (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_num    (w_num_x),
        .i_den    (r_s4_den),
        .o_quo    (w_quo_x),
        .o_rem_nz (w_rnz_x)
    );

    wsp_div #(
        .NUM_W (NUM_W),
        .DEN_W (CLIP_W),
        .QUO_W (QUO_W)
    ) u_div_y (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_num    (w_num_y),
        .i_den    (r_s4_den),
        .o_quo    (w_quo_y),
        .o_rem_nz (w_rnz_y)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
            for (int i = 0; i < DLY; i++) begin
                r_side[i].valid <= 1'b0;
            end
            r_s6_valid <= 1'b0;
            r_s7_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_s1_valid <= o_pop && i_entry.kind == KIND_PROJECT;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
            r_side[0].valid <= w_side_in.valid;
            for (int i = 1; i < DLY; i++) begin
                r_side[i].valid <= r_side[i-1].valid;
            end
            r_s6_valid <= w_side_out.valid;
            r_s7_valid <= r_s6_valid;
            r_out_valid <= r_s7_valid;
        end

        if (w_en) begin
            r_s1_x <= i_entry.x;
            r_s1_y <= i_entry.y;
            r_s1_z <= i_entry.z;
            for (int i = 0; i < 8; i++) begin
                r_s1_m[i] <= r_mat[i];
            end
            for (int i = 0; i < 4; i++) begin
                r_s1_m[8+i] <= r_mat[12+i];
            end

            for (int r = 0; r < 3; r++) begin
                r_s2_p[3*r]   <= r_s1_x * r_s1_m[4*r];
                r_s2_p[3*r+1] <= r_s1_y * r_s1_m[4*r+1];
                r_s2_p[3*r+2] <= r_s1_z * r_s1_m[4*r+2];
                r_s2_c[r]     <= r_s1_m[4*r+3];
            end

            for (int r = 0; r < 3; r++) begin
                r_s3_clip[r] <= fl(r_s2_p[3*r]) + fl(r_s2_p[3*r+1])
                              + fl(r_s2_p[3*r+2]) + cx(r_s2_c[r]);
            end

            // A zero w only passes the near test with a zero limit; it counts as behind.
            r_s4_behind <= (r_s3_clip[2] <= 0)
                        || (r_s3_clip[2] < $signed({{(CLIP_W-NEAR_W){1'b0}}, r_near}));
            r_s4_neg_x <= r_s3_clip[0][CLIP_W-1];
            r_s4_neg_y <= r_s3_clip[1][CLIP_W-1];
            r_s4_mag_x <= mag(r_s3_clip[0]);
            r_s4_mag_y <= mag(r_s3_clip[1]);
            r_s4_den <= r_s3_clip[2];

            r_side[0].behind <= w_side_in.behind;
            r_side[0].neg_x <= w_side_in.neg_x;
            r_side[0].neg_y <= w_side_in.neg_y;
            r_side[0].ov_x <= w_side_in.ov_x;
            r_side[0].ov_y <= w_side_in.ov_y;
            for (int i = 1; i < DLY; i++) begin
                r_side[i].behind <= r_side[i-1].behind;
                r_side[i].neg_x <= r_side[i-1].neg_x;
                r_side[i].neg_y <= r_side[i-1].neg_y;
                r_side[i].ov_x <= r_side[i-1].ov_x;
                r_side[i].ov_y <= r_side[i-1].ov_y;
            end

            r_s6_behind <= w_side_out.behind;
            r_s6_ndc_x <= ndc(w_quo_x, w_rnz_x, w_side_out.neg_x, w_side_out.ov_x);
            r_s6_ndc_y <= ndc(w_quo_y, w_rnz_y, w_side_out.neg_y, w_side_out.ov_y);

            r_s7_behind <= r_s6_behind;
            r_s7_px <= $signed({1'b0, r_width})
                     * (w_one + $signed({r_s6_ndc_x[NDC_W-1], r_s6_ndc_x}));
            r_s7_py <= $signed({1'b0, r_height})
                     * (w_one - $signed({r_s6_ndc_y[NDC_W-1], r_s6_ndc_y}));

            r_out_behind <= r_s7_behind;
            if (r_s7_behind) begin
                r_out_data <= '0;
            end else begin
                r_out_data <= {sat(r_s7_py), sat(r_s7_px)};
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata = r_out_data;
    assign o_m_tuser = r_out_behind;

endmodule

`default_nettype wire
